FILE: rtl/tli_pkg.sv
// Shared types and codes for the table interpolator.
package tli_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [2*DATA_W-1:0]      dword_t;
  typedef logic [1:0]               status_t;

  // item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // result status codes
  localparam status_t STATUS_OK     = 2'd0;
  localparam status_t STATUS_RANGE  = 2'd1;
  localparam status_t STATUS_COLUMN = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

endpackage

FILE: rtl/table_linear_interpolator_unit.sv
// Piecewise linear table interpolator: table store, row scan and interpolation control.
//
// Input channel (in_valid/in_ready): a write item (in_func = 0) stores in_word at
// (in_row, in_column); a query item (in_func = 1) interpolates column in_query_column
// (1-based) at key in_query_key. Each item gives exactly one result item on the
// output channel (out_valid/out_ready): out_value and out_status.
// Configuration goes through the APB port: rows_in_use at 0x0, columns_in_use at 0x4;
// write it only while the block is idle.
// Flow: one item is in work at a time. A write or a column error goes straight to the
// done state and from there into the output register. A query scans the key column one
// row per cycle through the single RAM port, then reads two words, multiplies and runs
// the divide; a key outside the table answers once the scan has reached the last row
// in use (rows_in_use as saturated into its legal range).
// The next item is taken once the result sits in the output register.
// Reset (synchronous, rst_n low) returns the control to idle, drops out_valid and
// sets both registers to 2; the table contents stay undefined until written.
// A stall on out_ready holds the result register; the block then finishes its
// current item and waits before taking another.
module table_linear_interpolator_unit
  import tli_pkg::*;
#(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [5:0]  in_row,
  input  logic [3:0]  in_column,
  input  word_t       in_word,
  input  word_t       in_query_key,
  input  logic [4:0]  in_query_column,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output word_t       out_value,
  output status_t     out_status,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLUMNS + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_EL1, ST_EL2, ST_ELW, ST_MUL, ST_DIV_GO, ST_DIV_WAIT, ST_DONE
  } state_t;

  // ---------------------------------------------------------------- config
  logic [6:0] rows_in_use_r;
  logic [4:0] columns_in_use_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r    <= 7'd2;
      columns_in_use_r <= 5'd2;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ROWS) begin
        rows_in_use_r <= pwdata[6:0];
      end else begin
        columns_in_use_r <= pwdata[4:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_COLS) ? 32'(columns_in_use_r) : 32'(rows_in_use_r);

  logic [RCW-1:0] rows_eff;
  logic [CW-1:0]  cols_eff;

  always_comb begin
    if (rows_in_use_r < 7'd2) begin
      rows_eff = RCW'(2);
    end else if (32'(rows_in_use_r) > 32'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(rows_in_use_r);
    end
    if (columns_in_use_r < 5'd2) begin
      cols_eff = CW'(2);
    end else if (32'(columns_in_use_r) > 32'(MAX_COLUMNS)) begin
      cols_eff = CW'(MAX_COLUMNS);
    end else begin
      cols_eff = CW'(columns_in_use_r);
    end
  end

  // ---------------------------------------------------------------- datapath regs
  state_t         state_r, state_nxt;
  word_t          key_r, key_nxt;
  word_t          prev_r, prev_nxt;
  word_t          t1_r, t1_nxt;
  word_t          t2_r, t2_nxt;
  word_t          el1_r, el1_nxt;
  logic [4:0]     col_r, col_nxt;
  logic [RCW-1:0] issue_row_r, issue_row_nxt;
  logic [RCW-1:0] rsp_row_r, rsp_row_nxt;
  logic [AW-1:0]  issue_addr_r, issue_addr_nxt;
  logic [AW-1:0]  rsp_addr_r, rsp_addr_nxt;
  logic [AW-1:0]  base1_r, base1_nxt;
  logic           rsp_vld_r, rsp_vld_nxt;
  logic [32:0]    mag_r, mag_nxt;
  logic [31:0]    dk_r, dk_nxt;
  logic [31:0]    dt_r, dt_nxt;
  logic           neg_r, neg_nxt;
  dword_t         prod_r, prod_nxt;
  word_t          res_value_r, res_value_nxt;
  status_t        res_status_r, res_status_nxt;
  logic           out_valid_r, out_valid_nxt;
  word_t          out_value_r, out_value_nxt;
  status_t        out_status_r, out_status_nxt;

  // ---------------------------------------------------------------- memory
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [AW-1:0] wr_addr;
  word_t         mem_rdata;
  logic          wr_in_range;

  tli_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_word),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------- divider
  logic  div_start;
  logic  div_done;
  word_t div_quo;

  tli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (dt_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------- control
  logic           accept;
  logic           issue;
  logic signed [32:0] del;
  logic [32:0]    dk_full;
  logic [32:0]    dt_full;
  dword_t         prod_mul;
  logic [33:0]    sum;

  assign in_ready    = (state_r == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign wr_in_range = (32'(in_row) < 32'(MAX_ROWS)) && (32'(in_column) < 32'(MAX_COLUMNS));
  assign wr_addr     = AW'(in_row) * AW'(MAX_COLUMNS) + AW'(in_column);
  assign issue       = (state_r == ST_SCAN) && (issue_row_r < rows_eff);

  assign del      = {mem_rdata[31], mem_rdata} - {el1_r[31], el1_r};
  assign dk_full  = {key_r[31], key_r} - {t1_r[31], t1_r};
  assign dt_full  = {t2_r[31], t2_r} - {t1_r[31], t1_r};
  assign prod_mul = mag_r[31:0] * dk_r;
  assign sum      = neg_r ? ({{2{el1_r[31]}}, el1_r} - {2'b00, div_quo})
                          : ({{2{el1_r[31]}}, el1_r} + {2'b00, div_quo});

  always_comb begin
    mem_we    = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: mem_addr = wr_addr;
      ST_EL1:  mem_addr = base1_r + AW'(col_r);
      ST_EL2:  mem_addr = base1_r + AW'(MAX_COLUMNS) + AW'(col_r);
      default: mem_addr = issue_addr_r;
    endcase
    if (accept && in_func == FUNC_WRITE && wr_in_range) begin
      mem_we = 1'b1;
    end
    if (state_r == ST_DIV_GO) begin
      div_start = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    prev_nxt       = prev_r;
    t1_nxt         = t1_r;
    t2_nxt         = t2_r;
    el1_nxt        = el1_r;
    col_nxt        = col_r;
    issue_row_nxt  = issue_row_r;
    rsp_row_nxt    = issue_row_r;
    issue_addr_nxt = issue_addr_r;
    rsp_addr_nxt   = issue_addr_r;
    base1_nxt      = base1_r;
    mag_nxt        = mag_r;
    dk_nxt         = dk_r;
    dt_nxt         = dt_r;
    neg_nxt        = neg_r;
    prod_nxt       = prod_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_value_nxt  = '0;
          res_status_nxt = STATUS_OK;
          if (in_func == FUNC_WRITE) begin
            state_nxt = ST_DONE;
          end else if (in_query_column == 5'd0 ||
                       32'(in_query_column) > 32'(cols_eff)) begin
            res_status_nxt = STATUS_COLUMN;
            state_nxt      = ST_DONE;
          end else begin
            key_nxt        = in_query_key;
            col_nxt        = in_query_column - 5'd1;
            issue_row_nxt  = '0;
            issue_addr_nxt = '0;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // reads go out one row a cycle; rsp_* tracks the row whose key just came back
        if (issue) begin
          issue_row_nxt  = issue_row_r + RCW'(1);
          issue_addr_nxt = issue_addr_r + AW'(MAX_COLUMNS);
        end
        if (rsp_vld_r) begin
          prev_nxt = mem_rdata;
          if (rsp_row_r != '0) begin
            if (key_r >= prev_r && key_r < mem_rdata) begin
              t1_nxt    = prev_r;
              t2_nxt    = mem_rdata;
              base1_nxt = rsp_addr_r - AW'(MAX_COLUMNS);
              state_nxt = ST_EL1;
            end else if (rsp_row_r == rows_eff - RCW'(1)) begin
              res_status_nxt = STATUS_RANGE;
              state_nxt      = ST_DONE;
            end
          end
        end
      end
      ST_EL1: begin
        state_nxt = ST_EL2;
      end
      ST_EL2: begin
        el1_nxt   = mem_rdata;
        state_nxt = ST_ELW;
      end
      ST_ELW: begin
        neg_nxt   = del[32];
        mag_nxt   = del[32] ? (33'd0 - del) : del;
        dk_nxt    = dk_full[31:0];
        dt_nxt    = dt_full[31:0];
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // magnitude of 2^32 only when the low word is zero
        prod_nxt  = mag_r[32] ? {dk_r, 32'd0} : prod_mul;
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          res_status_nxt = STATUS_OK;
          if (sum[33:31] != 3'b000 && sum[33:31] != 3'b111) begin
            res_value_nxt = sum[33] ? word_t'(32'h8000_0000) : word_t'(32'h7FFF_FFFF);
          end else begin
            res_value_nxt = sum[31:0];
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    rsp_vld_nxt = issue && (state_nxt == ST_SCAN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rsp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rsp_vld_r   <= rsp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r        <= key_nxt;
    prev_r       <= prev_nxt;
    t1_r         <= t1_nxt;
    t2_r         <= t2_nxt;
    el1_r        <= el1_nxt;
    col_r        <= col_nxt;
    issue_row_r  <= issue_row_nxt;
    rsp_row_r    <= rsp_row_nxt;
    issue_addr_r <= issue_addr_nxt;
    rsp_addr_r   <= rsp_addr_nxt;
    base1_r      <= base1_nxt;
    mag_r        <= mag_nxt;
    dk_r         <= dk_nxt;
    dt_r         <= dt_nxt;
    neg_r        <= neg_nxt;
    prod_r       <= prod_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

FILE: rtl/tli_ram.sv
// Generic single-port RAM with registered read data.
module tli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/tli_div.sv
// Radix-2 restoring divider: 64-bit dividend by 32-bit divisor, 32-bit quotient.
module tli_div
  import tli_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  dword_t       dividend,
  input  word_t        divisor,
  output logic         done,
  output word_t        quotient
);

  // caller guarantees dividend[63:32] < divisor, so the quotient fits 32 bits
  logic              busy_r;
  logic              done_r;
  logic [4:0]        cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] low_r;
  logic [DATA_W-1:0] dvs_r;

  logic [DATA_W:0]   sh;
  logic [DATA_W:0]   diff;
  logic              qbit;

  assign sh   = {rem_r, low_r[DATA_W-1]};
  assign diff = sh - {1'b0, dvs_r};
  assign qbit = (sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // one-cycle pulse after the last iteration
      done_r <= busy_r && !start && (cnt_r == 5'd31);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[2*DATA_W-1:DATA_W];
      low_r <= dividend[DATA_W-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
      low_r <= {low_r[DATA_W-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = low_r;

endmodule
